// ===== design/dinucleotide_window_masker_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dinucleotide window masker
// Immediate-style wrappers around concurrent properties; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef DINUCLEOTIDE_WINDOW_MASKER_MACROS_SVH
`define DINUCLEOTIDE_WINDOW_MASKER_MACROS_SVH

`ifndef SYNTHESIS
// cond must hold at every clock edge out of reset
`define DWM_ASSERT(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("dwm: property violated");
// cons must hold in the cycle after ante
`define DWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dwm: property violated");
`else
`define DWM_ASSERT(label, clk, rst_n, cond)
`define DWM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/dwm_pkg.sv =====
// ----------------------------------------------------------------------------
// dwm_pkg
// Shared widths, reset values and the result record of the window masker.
// ----------------------------------------------------------------------------
package dwm_pkg;

	localparam int WINDOW_DEF = 20;
	localparam int CNT_W      = 7;
	localparam int THR_W      = 7;
	localparam int MERGE_W    = 16;
	localparam int POS_W      = 32;
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic [THR_W-1:0]   THR_RST   = 7'd16;
	localparam logic [MERGE_W-1:0] MERGE_RST = 16'd15;
	localparam logic [POS_W-1:0]   POS_MAX   = 32'hFFFF_FFFF;

	// register index, taken from paddr[2]
	localparam logic REG_THR   = 1'b0;
	localparam logic REG_MERGE = 1'b1;

	typedef struct packed {
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] stop;
		logic             ivalid;
		logic             done;
	} result_t;

endpackage

// ===== design/dinucleotide_window_masker.sv =====
// A base accepted into stage 1 is evaluated once the output queue has room;
// its records are shown from the following cycle on. Throughput: one base per
// cycle while the queue has room, set by the window memory read on accept,
// ahead of the count update. Up to two records per base leave through a
// four-entry output queue, which stalls the pipe when it has under two free.
// Reset clears control state and registers; the window memory is not cleared.
// ----------------------------------------------------------------------------
// dinucleotide_window_masker
// Sliding-window base counter that flags windows rich in two base codes and
// merges flagged windows into masked intervals.
// ----------------------------------------------------------------------------
`include "dinucleotide_window_masker_macros.svh"

module dinucleotide_window_masker #(
	parameter int WINDOW = dwm_pkg::WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// sequence input
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 base,
	input  logic                       seq_last,
	// interval output
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dwm_pkg::POS_W-1:0]  interval_start,
	output logic [dwm_pkg::POS_W-1:0]  interval_end,
	output logic                       interval_valid,
	output logic                       sequence_done,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dwm_pkg::ADDR_W-1:0] paddr,
	input  logic [dwm_pkg::DATA_W-1:0] pwdata,
	output logic [dwm_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import dwm_pkg::*;

	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	// configuration registers
	logic [THR_W-1:0]   thr_q;
	logic [MERGE_W-1:0] merge_q;

	// window memory and its write pointer
	logic [1:0]    win_mem [WINDOW];
	logic [AW-1:0] wr_ptr_q;

	// evaluation stage
	logic          valid_s1;
	logic [1:0]    base_s1;
	logic          last_s1;
	logic [AW-1:0] ptr_s1;
	logic [1:0]    old_base_s1;

	// sequence state
	logic [CNT_W-1:0] cnt_q [4];
	logic [POS_W-1:0] pos_q;
	logic             open_q;
	logic [POS_W-1:0] open_start_q;
	logic [POS_W-1:0] open_end_q;

	// output queue
	result_t          fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] head_q;
	logic [FIFO_AW-1:0] tail_q;
	logic [FIFO_AW:0]   fill_q;

	logic in_fire;
	logic s1_fire;
	logic out_fire;
	logic cfg_wr;

	logic             full;
	logic             flagged;
	logic [POS_W-1:0] lo;
	logic             gap_far;
	logic             push_close;
	logic             push_final;
	logic             open_nx;
	logic [POS_W-1:0] open_start_nx;
	logic [POS_W-1:0] open_end_nx;
	logic [CNT_W-1:0] cnt_nx [4];
	result_t          rec_close;
	result_t          rec_final;
	logic [FIFO_AW:0] push_n;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;

	assign s1_fire  = valid_s1 && (fill_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
	assign in_ready = !valid_s1 || s1_fire;
	assign in_fire  = in_valid && in_ready;
	assign out_valid = (fill_q != '0);
	assign out_fire  = out_valid && out_ready;

	assign interval_start = fifo_q[head_q].start;
	assign interval_end   = fifo_q[head_q].stop;
	assign interval_valid = fifo_q[head_q].ivalid;
	assign sequence_done  = fifo_q[head_q].done;

	always_comb begin
		unique case (paddr[2])
			REG_THR:   prdata = DATA_W'(thr_q);
			REG_MERGE: prdata = DATA_W'(merge_q);
			default:   prdata = '0;
		endcase
	end

	// pair test, interval update and count update for the base in stage 1
	always_comb begin
		full    = (pos_q >= POS_W'(WINDOW));
		lo      = pos_q - POS_W'(WINDOW);
		flagged = 1'b0;
		for (int a = 0; a < 4; a++) begin
			for (int b = a + 1; b < 4; b++) begin
				if ({1'b0, cnt_q[a]} + {1'b0, cnt_q[b]} > {1'b0, thr_q})
					flagged = 1'b1;
			end
		end
		gap_far = {1'b0, lo} > ({1'b0, open_end_q} + (POS_W+1)'(merge_q));

		push_close    = 1'b0;
		open_nx       = open_q;
		open_start_nx = open_start_q;
		open_end_nx   = open_end_q;
		if (full && flagged) begin
			if (!open_q) begin
				open_nx       = 1'b1;
				open_start_nx = lo;
				open_end_nx   = pos_q;
			end else if (gap_far) begin
				push_close    = 1'b1;
				open_start_nx = lo;
				open_end_nx   = pos_q;
			end else begin
				open_end_nx   = pos_q;
			end
		end
		push_final = last_s1;

		rec_close = '{start: open_start_q, stop: open_end_q, ivalid: 1'b1, done: 1'b0};
		if (open_nx)
			rec_final = '{start: open_start_nx, stop: open_end_nx, ivalid: 1'b1, done: 1'b1};
		else
			rec_final = '{start: '0, stop: '0, ivalid: 1'b0, done: 1'b1};

		for (int k = 0; k < 4; k++) begin
			cnt_nx[k] = cnt_q[k];
			if (full && (old_base_s1 == 2'(k)))
				cnt_nx[k] = cnt_nx[k] - 1'b1;
			if (base_s1 == 2'(k))
				cnt_nx[k] = cnt_nx[k] + 1'b1;
		end

		push_n = '0;
		if (s1_fire)
			push_n = (FIFO_AW+1)'(push_close) + (FIFO_AW+1)'(push_final);
	end

	// window memory: read the oldest entry on accept, write the new base in stage 1
	always_ff @(posedge clk) begin
		if (in_fire)
			old_base_s1 <= win_mem[wr_ptr_q];
		if (s1_fire)
			win_mem[ptr_s1] <= base_s1;
	end

	// stage payload and queue entries
	always_ff @(posedge clk) begin
		if (in_fire) begin
			base_s1 <= base;
			last_s1 <= seq_last;
			ptr_s1  <= wr_ptr_q;
		end
		if (s1_fire) begin
			if (push_close) begin
				fifo_q[tail_q]                    <= rec_close;
				if (push_final)
					fifo_q[tail_q + FIFO_AW'(1)] <= rec_final;
			end else if (push_final) begin
				fifo_q[tail_q]                    <= rec_final;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= THR_RST;
			merge_q      <= MERGE_RST;
			wr_ptr_q     <= '0;
			valid_s1     <= 1'b0;
			pos_q        <= '0;
			open_q       <= 1'b0;
			open_start_q <= '0;
			open_end_q   <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
			for (int k = 0; k < 4; k++)
				cnt_q[k] <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_THR:   thr_q   <= pwdata[THR_W-1:0];
					REG_MERGE: merge_q <= pwdata[MERGE_W-1:0];
					default:   ;
				endcase
			end

			if (in_fire) begin
				// advance the circular write pointer
				if (wr_ptr_q == AW'(WINDOW - 1))
					wr_ptr_q <= '0;
				else
					wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (in_fire)
				valid_s1 <= 1'b1;
			else if (s1_fire)
				valid_s1 <= 1'b0;

			if (s1_fire) begin
				if (last_s1) begin
					// drop the sequence state; the memory needs no clearing
					pos_q        <= '0;
					open_q       <= 1'b0;
					open_start_q <= '0;
					open_end_q   <= '0;
					for (int k = 0; k < 4; k++)
						cnt_q[k] <= '0;
				end else begin
					if (pos_q != POS_MAX)
						pos_q <= pos_q + 1'b1;
					open_q       <= open_nx;
					open_start_q <= open_start_nx;
					open_end_q   <= open_end_nx;
					for (int k = 0; k < 4; k++)
						cnt_q[k] <= cnt_nx[k];
				end
			end

			tail_q <= tail_q + push_n[FIFO_AW-1:0];
			if (out_fire)
				head_q <= head_q + 1'b1;
			fill_q <= fill_q + push_n - (FIFO_AW+1)'(out_fire);
		end
	end

	logic [CNT_W+1:0] cnt_sum;
	assign cnt_sum = (CNT_W+2)'(cnt_q[0]) + (CNT_W+2)'(cnt_q[1])
		+ (CNT_W+2)'(cnt_q[2]) + (CNT_W+2)'(cnt_q[3]);

	`DWM_ASSERT(a_fifo_bound, clk, arst_n, fill_q <= (FIFO_AW+1)'(FIFO_DEPTH))
	`DWM_ASSERT(a_cnt_sum, clk, arst_n, cnt_sum <= (CNT_W+2)'(WINDOW))
	`DWM_ASSERT(a_open_order, clk, arst_n, !open_q || (open_end_q >= open_start_q))
	`DWM_ASSERT_NEXT(a_pos_mono, clk, arst_n, s1_fire && !last_s1, pos_q >= $past(pos_q))

endmodule

// ===== bench/tb_dinucleotide_window_masker.sv =====
// ----------------------------------------------------------------------------
// tb_dinucleotide_window_masker
// Streams base sequences through the masker under random handshake gaps and
// compares every interval record against a cycle-free window/interval model.
// ----------------------------------------------------------------------------
module tb_dinucleotide_window_masker;
	import dwm_pkg::*;

	localparam int WIN    = WINDOW_DEF;
	localparam int PHASES = 10;
	localparam int BUDGET = 108;
	localparam int SETTLE = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] base = 2'd0;
	logic seq_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [POS_W-1:0] interval_start;
	logic [POS_W-1:0] interval_end;
	logic interval_valid;
	logic sequence_done;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// -1 draws a random value for that phase
	int thr_plan [PHASES] = '{0, 64, 16, 15, 39, 40, 19, 10, -1, 1};
	int merge_plan [PHASES] = '{0, 65535, 15, 0, 65535, 7, 0, 3, -1, 30};

	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;
	int settings_used = 0;

	class interval_scoreboard;
		logic [THR_W-1:0] thr;
		logic [MERGE_W-1:0] merge;
		logic [1:0] win [WIN];
		logic [CNT_W-1:0] cnt [4];
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] open_start;
		logic [POS_W-1:0] open_end;
		logic open_flag;
		result_t records_due [$];
		int errors;
		int bases;
		int seqs;
		int records;

		function new();
			thr = THR_RST;
			merge = MERGE_RST;
			errors = 0;
			bases = 0;
			seqs = 0;
			records = 0;
			clear_seq();
		endfunction

		function void clear_seq();
			foreach (win[k]) win[k] = 2'd0;
			foreach (cnt[k]) cnt[k] = '0;
			pos = '0;
			open_flag = 1'b0;
			open_start = '0;
			open_end = '0;
		endfunction

		function void set_reg(logic idx, logic [DATA_W-1:0] value);
			if (idx == REG_THR)
				thr = value[THR_W-1:0];
			else
				merge = value[MERGE_W-1:0];
		endfunction

		function bit window_hot();
			for (int a = 0; a < 4; a++)
				for (int b = a + 1; b < 4; b++)
					if (int'(cnt[a]) + int'(cnt[b]) > int'(thr))
						return 1'b1;
			return 1'b0;
		endfunction

		// true when the next base, whatever it is, closes the open interval
		function bit would_close();
			longint lo;
			if (pos < WIN || !open_flag || !window_hot())
				return 1'b0;
			lo = longint'(pos) - WIN;
			return lo > longint'(open_end) + longint'(merge);
		endfunction

		function void push_record(logic [POS_W-1:0] s, logic [POS_W-1:0] e, logic v, logic d);
			result_t rec;
			rec.start = s;
			rec.stop = e;
			rec.ivalid = v;
			rec.done = d;
			records_due.insert(records_due.size(), rec);
		endfunction

		function void note_base(logic [1:0] b, logic last);
			logic [POS_W-1:0] lo;
			logic [1:0] old;
			bit full;
			full = pos >= WIN;
			if (full && window_hot()) begin
				lo = pos - WIN;
				if (!open_flag) begin
					open_flag = 1'b1;
					open_start = lo;
					open_end = pos;
				end else if (longint'(lo) > longint'(open_end) + longint'(merge)) begin
					push_record(open_start, open_end, 1'b1, 1'b0);
					open_start = lo;
					open_end = pos;
				end else begin
					open_end = pos;
				end
			end
			if (full) begin
				old = win[WIN-1];
				cnt[old] = cnt[old] - 1'b1;
			end
			for (int k = WIN - 1; k > 0; k--)
				win[k] = win[k-1];
			win[0] = b;
			cnt[b] = cnt[b] + 1'b1;
			if (pos != POS_MAX)
				pos = pos + 1'b1;
			if (last) begin
				if (open_flag)
					push_record(open_start, open_end, 1'b1, 1'b1);
				else
					push_record('0, '0, 1'b0, 1'b1);
				clear_seq();
				seqs++;
			end
			bases++;
		endfunction

		function bit field_ok(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
			if (want === got)
				return 1'b1;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			return 1'b0;
		endfunction

		function void check_record(result_t got);
			result_t want;
			bit ok;
			records++;
			if (records_due.size() == 0) begin
				errors++;
				$display("%0t: record with none expected, actual start %0d end %0d valid %0b done %0b",
					$time, got.start, got.stop, got.ivalid, got.done);
				return;
			end
			want = records_due.pop_front();
			ok = field_ok("interval_start", want.start, got.start);
			ok &= field_ok("interval_end", want.stop, got.stop);
			ok &= field_ok("interval_valid", want.ivalid, got.ivalid);
			ok &= field_ok("sequence_done", want.done, got.done);
			if (!ok)
				errors++;
		endfunction

		function int outstanding();
			return records_due.size();
		endfunction
	endclass

	interval_scoreboard sb = new();

	dinucleotide_window_masker #(.WINDOW(WIN)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.base(base),
		.seq_last(seq_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.interval_start(interval_start),
		.interval_end(interval_end),
		.interval_valid(interval_valid),
		.sequence_done(sequence_done),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("dinucleotide_window_masker test failed");
		$finish;
	end

	function automatic int draw_gap(bit steady);
		return steady ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic send_base(logic [1:0] b, logic last);
		int gap;
		gap = draw_gap(send_steady);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		base <= b;
		seq_last <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_base(b, last);
	endtask

	// hold the input until every expected record is back, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_rw(input logic wr, input logic idx, input logic [DATA_W-1:0] wdata,
		output logic [DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_write(logic idx, logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] rd;
		logic [DATA_W-1:0] want;
		apb_rw(1'b1, idx, value, rd);
		apb_rw(1'b0, idx, '0, rd);
		want = (idx == REG_THR) ? (value & ((1 << THR_W) - 1)) : (value & ((1 << MERGE_W) - 1));
		if (rd !== want) begin
			sb.errors++;
			$display("%0t: readback of register %0d, expected %0d, actual %0d", $time, idx, want, rd);
		end
		sb.set_reg(idx, value);
	endtask

	task automatic run_random(int budget);
		int sent;
		int len;
		int seg_left;
		int rich_a;
		int rich_b;
		int bias;
		bit cut_early;
		logic [1:0] b;
		logic last;
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(0, 9))
				0: len = $urandom_range(1, WIN);
				9: len = $urandom_range(150, 300);
				default: len = $urandom_range(WIN + 1, WIN + 100);
			endcase
			if (len > budget - sent)
				len = budget - sent;
			cut_early = ($urandom_range(0, 2) == 0);
			send_steady = ($urandom_range(0, 3) == 0);
			seg_left = 0;
			for (int k = 0; k < len; k++) begin
				// segments rich in one or two codes push pair counts over the threshold
				if (seg_left == 0) begin
					seg_left = $urandom_range(5, 40);
					rich_a = $urandom_range(0, 3);
					rich_b = $urandom_range(0, 3);
					bias = $urandom_range(0, 16);
				end
				seg_left--;
				if ($urandom_range(1, 16) <= bias)
					b = $urandom_range(0, 1) ? rich_a[1:0] : rich_b[1:0];
				else
					b = $urandom_range(0, 3);
				last = (k == len - 1) || (cut_early && sb.would_close());
				send_base(b, last);
				sent++;
				if (last)
					break;
			end
			if ($urandom_range(0, 7) == 0)
				drain();
		end
	endtask

	// receiver: random back-pressure, with stretches of steady ready
	initial begin
		int gap;
		result_t got;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 23) == 0)
				recv_steady = !recv_steady;
			gap = draw_gap(recv_steady);
			repeat (gap) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.start = interval_start;
			got.stop = interval_end;
			got.ivalid = interval_valid;
			got.done = sequence_done;
			sb.check_record(got);
		end
	end

	initial begin
		logic [DATA_W-1:0] thr_val;
		logic [DATA_W-1:0] merge_val;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: single-base sequences at both code extremes, then a short one
		send_base(2'd0, 1'b1);
		send_base(2'd3, 1'b1);
		for (int k = 0; k < WIN; k++)
			send_base(k[1:0], k == WIN - 1);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			thr_val = (thr_plan[p] < 0) ? $urandom_range(0, 64) : thr_plan[p];
			merge_val = (merge_plan[p] < 0) ? $urandom_range(0, 65535) : merge_plan[p];
			reg_write(REG_THR, thr_val);
			reg_write(REG_MERGE, merge_val);
			settings_used++;
			run_random(BUDGET);
			drain();
		end

		$display("covered %0d bases in %0d sequences over %0d register settings,",
			sb.bases, sb.seqs, settings_used);
		$display("checked %0d interval records, %0d mismatching", sb.records, sb.errors);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("dinucleotide_window_masker test passed");
		else
			$display("dinucleotide_window_masker test failed");
		$finish;
	end

endmodule
